// ===== hdl/cdsc_pkg.sv =====
// Shared types, codes and month table for the calendar date/time step counter.
package cdsc_pkg;

	// Year register width; the year wraps modulo 2**YEAR_BITS
	localparam int YEAR_BITS = 16;

	// Field limits
	localparam logic [5:0] MINUTE_MAX = 6'd59;
	localparam logic [4:0] HOUR_MAX   = 5'd23;
	localparam logic [3:0] MONTH_MAX  = 4'd12;
	localparam logic [3:0] MONTH_MIN  = 4'd1;
	localparam logic [4:0] DAY_MIN    = 5'd1;

	// Operation codes
	typedef enum logic [1:0] {
		OP_UP   = 2'd0,
		OP_DOWN = 2'd1,
		OP_SET  = 2'd2
	} cdsc_op_t;

	// Unit codes
	typedef enum logic [2:0] {
		UNIT_MINUTE = 3'd0,
		UNIT_HOUR   = 3'd1,
		UNIT_DAY    = 3'd2,
		UNIT_MONTH  = 3'd3,
		UNIT_YEAR   = 3'd4
	} cdsc_unit_t;

	// Full date and time
	typedef struct packed {
		logic [5:0]           minute;
		logic [4:0]           hour;
		logic [4:0]           day;
		logic [3:0]           month;
		logic [YEAR_BITS-1:0] year;
	} cdsc_date_t;

	// Value after reset: 00:00 on January 1st of year 0
	localparam cdsc_date_t DATE_RESET = '{
		minute: 6'd0,
		hour:   5'd0,
		day:    5'd1,
		month:  4'd1,
		year:   '0
	};

	// Month length, February fixed at 28; a month code outside 1..12 reads as January
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd2:    len = 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== hdl/cdsc_step.sv =====
// Next-state logic: step up, step down or set one unit of the date/time.
module cdsc_step (
	input  cdsc_pkg::cdsc_date_t cur,
	input  logic [1:0]           op,
	input  logic [2:0]           unit,
	input  logic [15:0]          value,
	output cdsc_pkg::cdsc_date_t nxt,
	output logic                 rejected
);

	cdsc_pkg::cdsc_op_t   op_e;
	cdsc_pkg::cdsc_unit_t unit_e;

	// One-hot style unit requests for the step chains
	logic sel_min, sel_hour, sel_day, sel_month, sel_year;
	logic up, dn;

	// Carry chain (up) and borrow chain (down)
	logic hour_inc, day_inc, month_inc, year_inc;
	logic hour_dec, day_dec, month_dec, year_dec;
	logic min_wrap_up, hour_wrap_up, day_wrap_up, month_wrap_up;
	logic min_wrap_dn, hour_wrap_dn, day_wrap_dn, month_wrap_dn;

	logic [3:0] month_step;
	logic [4:0] cur_len;

	assign op_e   = cdsc_pkg::cdsc_op_t'(op);
	assign unit_e = cdsc_pkg::cdsc_unit_t'(unit);

	assign up = (op_e == cdsc_pkg::OP_UP);
	assign dn = (op_e == cdsc_pkg::OP_DOWN);

	assign sel_min   = (unit_e == cdsc_pkg::UNIT_MINUTE);
	assign sel_hour  = (unit_e == cdsc_pkg::UNIT_HOUR);
	assign sel_day   = (unit_e == cdsc_pkg::UNIT_DAY);
	assign sel_month = (unit_e == cdsc_pkg::UNIT_MONTH);
	assign sel_year  = (unit_e == cdsc_pkg::UNIT_YEAR);

	assign cur_len = cdsc_pkg::month_len(cur.month);

	// Carries ripple upward from the selected unit
	assign min_wrap_up   = up && sel_min && (cur.minute >= cdsc_pkg::MINUTE_MAX);
	assign hour_inc      = up && (sel_hour || min_wrap_up);
	assign hour_wrap_up  = hour_inc && (cur.hour >= cdsc_pkg::HOUR_MAX);
	assign day_inc       = up && (sel_day || hour_wrap_up);
	assign day_wrap_up   = day_inc && (cur.day >= cur_len);
	assign month_inc     = up && (sel_month || day_wrap_up);
	assign month_wrap_up = month_inc && (cur.month >= cdsc_pkg::MONTH_MAX);
	assign year_inc      = up && (sel_year || month_wrap_up);

	// Borrows ripple upward the same way
	assign min_wrap_dn   = dn && sel_min && (cur.minute == '0);
	assign hour_dec      = dn && (sel_hour || min_wrap_dn);
	assign hour_wrap_dn  = hour_dec && (cur.hour == '0);
	assign day_dec       = dn && (sel_day || hour_wrap_dn);
	assign day_wrap_dn   = day_dec && (cur.day <= cdsc_pkg::DAY_MIN);
	assign month_dec     = dn && (sel_month || day_wrap_dn);
	assign month_wrap_dn = month_dec && (cur.month <= cdsc_pkg::MONTH_MIN);
	assign year_dec      = dn && (sel_year || month_wrap_dn);

	// Month after a step; a day borrow loads the length of the new month
	always_comb begin
		month_step = cur.month;
		if (month_inc) begin
			month_step = month_wrap_up ? cdsc_pkg::MONTH_MIN : cur.month + 4'd1;
		end else if (month_dec) begin
			month_step = month_wrap_dn ? cdsc_pkg::MONTH_MAX : cur.month - 4'd1;
		end
	end

	// Assemble next state
	always_comb begin
		nxt      = cur;
		rejected = 1'b0;
		case (op_e)
			cdsc_pkg::OP_UP, cdsc_pkg::OP_DOWN: begin
				if (sel_min) begin
					if (up)
						nxt.minute = min_wrap_up ? '0 : cur.minute + 6'd1;
					else
						nxt.minute = min_wrap_dn ? cdsc_pkg::MINUTE_MAX : cur.minute - 6'd1;
				end
				if (hour_inc)
					nxt.hour = hour_wrap_up ? '0 : cur.hour + 5'd1;
				else if (hour_dec)
					nxt.hour = hour_wrap_dn ? cdsc_pkg::HOUR_MAX : cur.hour - 5'd1;
				if (day_inc)
					nxt.day = day_wrap_up ? cdsc_pkg::DAY_MIN : cur.day + 5'd1;
				else if (day_dec)
					nxt.day = day_wrap_dn ? cdsc_pkg::month_len(month_step)
					                      : cur.day - 5'd1;
				nxt.month = month_step;
				if (year_inc)
					nxt.year = cur.year + cdsc_pkg::YEAR_BITS'(1);
				else if (year_dec)
					nxt.year = cur.year - cdsc_pkg::YEAR_BITS'(1);
			end
			cdsc_pkg::OP_SET: begin
				case (unit_e)
					cdsc_pkg::UNIT_MINUTE: begin
						if (value <= 16'(cdsc_pkg::MINUTE_MAX))
							nxt.minute = value[5:0];
						else
							rejected = 1'b1;
					end
					cdsc_pkg::UNIT_HOUR: begin
						if (value <= 16'(cdsc_pkg::HOUR_MAX))
							nxt.hour = value[4:0];
						else
							rejected = 1'b1;
					end
					cdsc_pkg::UNIT_DAY: begin
						if (value >= 16'(cdsc_pkg::DAY_MIN) && value <= 16'(cur_len))
							nxt.day = value[4:0];
						else
							rejected = 1'b1;
					end
					cdsc_pkg::UNIT_MONTH: begin
						// day is left as is, even past the new month's end
						if (value >= 16'(cdsc_pkg::MONTH_MIN) &&
						    value <= 16'(cdsc_pkg::MONTH_MAX))
							nxt.month = value[3:0];
						else
							rejected = 1'b1;
					end
					cdsc_pkg::UNIT_YEAR: begin
						nxt.year = cdsc_pkg::YEAR_BITS'(value);
					end
					default: begin
						nxt = cur;
					end
				endcase
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== hdl/calendar_datetime_step_counter_unit.sv =====
// Top level: input register, date/time state, next-state logic and result register.
// Each item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the receiver does not stall; the state register
// updates in the same cycle an item leaves the input register, so the next item sees it
// at once.
// Reset: the date/time returns to 00:00, day 1, month 1, year 0, and both
// stages empty.
module calendar_datetime_step_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [2:0]  unit,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  minute_out,
	output logic [4:0]  hour_out,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [15:0] year_out,
	output logic        set_rejected
);

	// Input stage
	logic        valid_s1;
	logic [1:0]  operation_s1;
	logic [2:0]  unit_s1;
	logic [15:0] value_s1;

	// Result stage
	logic                 valid_s2;
	cdsc_pkg::cdsc_date_t date_s2;
	logic                 rejected_s2;

	// Architectural state
	cdsc_pkg::cdsc_date_t date_q;
	cdsc_pkg::cdsc_date_t date_nxt;
	logic                 rejected_nxt;

	logic advance;
	logic load_s1;

	// Stage handshake
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign load_s1  = in_valid && in_ready;

	cdsc_step u_step (
		.cur      (date_q),
		.op       (operation_s1),
		.unit     (unit_s1),
		.value    (value_s1),
		.nxt      (date_nxt),
		.rejected (rejected_nxt)
	);

	// Control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			date_q   <= cdsc_pkg::DATE_RESET;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
			if (advance)
				date_q <= date_nxt;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_s1) begin
			operation_s1 <= operation;
			unit_s1      <= unit;
			value_s1     <= value;
		end
		if (advance) begin
			date_s2     <= date_nxt;
			rejected_s2 <= rejected_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign minute_out   = date_s2.minute;
	assign hour_out     = date_s2.hour;
	assign day_out      = date_s2.day;
	assign month_out    = date_s2.month;
	assign year_out     = 16'(date_s2.year);
	assign set_rejected = rejected_s2;

endmodule

// ===== verif/cdsc_date_tracker.sv =====
// Date tracker: watches both channels, predicts each result, compares and counts mismatches.
module cdsc_date_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [2:0]  unit,
	input  logic [15:0] value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  minute_out,
	input  logic [4:0]  hour_out,
	input  logic [4:0]  day_out,
	input  logic [3:0]  month_out,
	input  logic [15:0] year_out,
	input  logic        set_rejected,
	output int          mismatch_total,
	output int          dates_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		cdsc_pkg::cdsc_date_t date;
		logic                 rejected;
	} date_result_t;

	// Days per month, February always 28
	int month_days [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	cdsc_pkg::cdsc_date_t clock_now;
	date_result_t         expected_dates [$];
	int                   errors;

	// Length of month m; a code outside 1..12 counts as January
	function automatic int days_in(logic [3:0] m);
		if (m < cdsc_pkg::MONTH_MIN || m > cdsc_pkg::MONTH_MAX)
			return month_days[1];
		return month_days[m];
	endfunction

	// Date after one item, plus the reject flag for a set
	function automatic date_result_t apply_item(cdsc_pkg::cdsc_date_t d, logic [1:0] op,
			logic [2:0] u, logic [15:0] v);
		date_result_t r;
		bit s_min, s_hour, s_day, s_month, s_year, refill_day;
		r.date = d;
		r.rejected = 1'b0;
		s_min = 0;
		s_hour = 0;
		s_day = 0;
		s_month = 0;
		s_year = 0;
		refill_day = 0;
		// Pick the unit that gets stepped first
		if (op == cdsc_pkg::OP_UP || op == cdsc_pkg::OP_DOWN) begin
			case (u)
				cdsc_pkg::UNIT_MINUTE: s_min = 1;
				cdsc_pkg::UNIT_HOUR:   s_hour = 1;
				cdsc_pkg::UNIT_DAY:    s_day = 1;
				cdsc_pkg::UNIT_MONTH:  s_month = 1;
				cdsc_pkg::UNIT_YEAR:   s_year = 1;
				default: ;
			endcase
		end
		case (op)
			// Step up, carrying upward
			cdsc_pkg::OP_UP: begin
				if (s_min) begin
					if (r.date.minute >= cdsc_pkg::MINUTE_MAX) begin
						r.date.minute = '0;
						s_hour = 1;
					end else
						r.date.minute++;
				end
				if (s_hour) begin
					if (r.date.hour >= cdsc_pkg::HOUR_MAX) begin
						r.date.hour = '0;
						s_day = 1;
					end else
						r.date.hour++;
				end
				// Day past month end (also after an unclamped month set) rolls over
				if (s_day) begin
					if (int'(r.date.day) + 1 > days_in(r.date.month)) begin
						r.date.day = cdsc_pkg::DAY_MIN;
						s_month = 1;
					end else
						r.date.day++;
				end
				if (s_month) begin
					if (r.date.month >= cdsc_pkg::MONTH_MAX) begin
						r.date.month = cdsc_pkg::MONTH_MIN;
						s_year = 1;
					end else
						r.date.month++;
				end
				if (s_year)
					r.date.year++;
			end
			// Step down, borrowing upward
			cdsc_pkg::OP_DOWN: begin
				if (s_min) begin
					if (r.date.minute == 0) begin
						r.date.minute = cdsc_pkg::MINUTE_MAX;
						s_hour = 1;
					end else
						r.date.minute--;
				end
				if (s_hour) begin
					if (r.date.hour == 0) begin
						r.date.hour = cdsc_pkg::HOUR_MAX;
						s_day = 1;
					end else
						r.date.hour--;
				end
				if (s_day) begin
					if (r.date.day <= cdsc_pkg::DAY_MIN) begin
						s_month = 1;
						refill_day = 1;
					end else
						r.date.day--;
				end
				if (s_month) begin
					if (r.date.month <= cdsc_pkg::MONTH_MIN) begin
						r.date.month = cdsc_pkg::MONTH_MAX;
						s_year = 1;
					end else
						r.date.month--;
				end
				if (s_year)
					r.date.year--;
				// Day borrow lands on the last day of the new month
				if (refill_day)
					r.date.day = 5'(days_in(r.date.month));
			end
			// Set with range check; day range follows the current month
			cdsc_pkg::OP_SET: begin
				case (u)
					cdsc_pkg::UNIT_MINUTE: begin
						if (v <= cdsc_pkg::MINUTE_MAX) r.date.minute = v[5:0];
						else r.rejected = 1'b1;
					end
					cdsc_pkg::UNIT_HOUR: begin
						if (v <= cdsc_pkg::HOUR_MAX) r.date.hour = v[4:0];
						else r.rejected = 1'b1;
					end
					cdsc_pkg::UNIT_DAY: begin
						if (v >= cdsc_pkg::DAY_MIN && v <= days_in(r.date.month))
							r.date.day = v[4:0];
						else r.rejected = 1'b1;
					end
					cdsc_pkg::UNIT_MONTH: begin
						if (v >= cdsc_pkg::MONTH_MIN && v <= cdsc_pkg::MONTH_MAX)
							r.date.month = v[3:0];
						else r.rejected = 1'b1;
					end
					cdsc_pkg::UNIT_YEAR: r.date.year = v;
					default: ;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Predict on each accepted item, compare on each accepted result
	always @(posedge clk or negedge arst_n) begin
		date_result_t want;
		if (!arst_n) begin
			clock_now = cdsc_pkg::DATE_RESET;
			expected_dates.delete();
			errors = 0;
			mismatch_total <= 0;
			dates_pending <= 0;
		end else begin
			if (in_valid && in_ready) begin
				want = apply_item(clock_now, operation, unit, value);
				clock_now = want.date;
				expected_dates.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_dates.size() == 0) begin
					$display("%0t: result with no item outstanding", $time);
					errors++;
				end else begin
					want = expected_dates.pop_front();
					check_field("minute_out", want.date.minute, minute_out);
					check_field("hour_out", want.date.hour, hour_out);
					check_field("day_out", want.date.day, day_out);
					check_field("month_out", want.date.month, month_out);
					check_field("year_out", want.date.year, year_out);
					check_field("set_rejected", want.rejected, set_rejected);
				end
			end
			mismatch_total <= errors;
			dates_pending <= expected_dates.size();
		end
	end

endmodule

// ===== verif/calendar_datetime_step_counter_unit_tb.sv =====
// Testbench top: clock, reset, directed and random items, random output stalls, verdict.
module calendar_datetime_step_counter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Codes the block must ignore
	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam logic [2:0] UNIT_UNUSED_LO = 3'd5;
	localparam logic [2:0] UNIT_UNUSED_HI = 3'd7;

	localparam int RANDOM_ITEMS = 625;
	localparam int STALL_LIMIT  = 2000;
	localparam int IDLE_PCT     = 13;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [2:0]  unit = '0;
	logic [15:0] value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  minute_out;
	logic [4:0]  hour_out;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [15:0] year_out;
	logic        set_rejected;
	logic        gaps_on = 1'b1;
	int          mismatch_total;
	int          dates_pending;
	int          stall_cycles = 0;

	always #5 clk = ~clk;

	calendar_datetime_step_counter_unit dut (.*);

	cdsc_date_tracker tracker (.*);

	// Receiver stalls at random while gaps are enabled
	always @(posedge clk)
		out_ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Present one item after a random gap and hold it until accepted
	task automatic send_item(logic [1:0] op, logic [2:0] u, logic [15:0] v);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		unit <= u;
		value <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (dates_pending != 0);
	endtask

	initial begin
		logic [1:0]  op;
		logic [2:0]  u;
		logic [15:0] v;
		int          pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: full borrow and carry chains, wraps, rejects, unclamped day
		send_item(cdsc_pkg::OP_DOWN, cdsc_pkg::UNIT_MINUTE, 16'd0);
		send_item(cdsc_pkg::OP_UP, cdsc_pkg::UNIT_MINUTE, 16'hFFFF);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_YEAR, 16'hFFFF);
		send_item(cdsc_pkg::OP_UP, cdsc_pkg::UNIT_YEAR, 16'd0);
		send_item(cdsc_pkg::OP_DOWN, cdsc_pkg::UNIT_YEAR, 16'd0);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MINUTE, 16'(cdsc_pkg::MINUTE_MAX));
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MINUTE,
			16'(cdsc_pkg::MINUTE_MAX) + 16'd1);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_HOUR, 16'(cdsc_pkg::HOUR_MAX));
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_HOUR, 16'(cdsc_pkg::HOUR_MAX) + 16'd1);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_DAY, 16'd31);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MONTH, 16'd2);
		send_item(cdsc_pkg::OP_UP, cdsc_pkg::UNIT_DAY, 16'd0);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_DAY, 16'd0);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MONTH, 16'd2);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_DAY, 16'd29);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_DAY, 16'd28);
		send_item(cdsc_pkg::OP_UP, cdsc_pkg::UNIT_HOUR, 16'd0);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MONTH,
			16'(cdsc_pkg::MONTH_MAX) + 16'd1);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MONTH, 16'd0);
		send_item(cdsc_pkg::OP_DOWN, cdsc_pkg::UNIT_DAY, 16'd0);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_MINUTE, 16'hFFFF);
		send_item(OP_UNUSED, cdsc_pkg::UNIT_MINUTE, 16'd7);
		send_item(cdsc_pkg::OP_SET, UNIT_UNUSED_HI, 16'd5);
		send_item(cdsc_pkg::OP_UP, UNIT_UNUSED_LO, 16'd0);
		send_item(cdsc_pkg::OP_SET, cdsc_pkg::UNIT_YEAR, 16'd0);

		// Sender holds off until the pipeline is empty
		drain();

		// Random: mostly steps and in-range sets, some rejects and ignored codes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 250)
				gaps_on <= 1'b0;
			if (n == 400)
				gaps_on <= 1'b1;
			pick = $urandom_range(99);
			if (pick < 40) op = cdsc_pkg::OP_UP;
			else if (pick < 68) op = cdsc_pkg::OP_DOWN;
			else if (pick < 96) op = cdsc_pkg::OP_SET;
			else op = OP_UNUSED;
			if ($urandom_range(99) < 5)
				u = 3'($urandom_range(UNIT_UNUSED_HI, UNIT_UNUSED_LO));
			else
				u = 3'($urandom_range(cdsc_pkg::UNIT_YEAR, cdsc_pkg::UNIT_MINUTE));
			pick = $urandom_range(99);
			if (pick < 20 || op != cdsc_pkg::OP_SET)
				v = 16'($urandom);
			else if (pick < 60) begin
				// Edges of each range, just inside, and for day and month also just outside
				case (u)
					cdsc_pkg::UNIT_MINUTE:
						v = $urandom_range(1) ? 16'(cdsc_pkg::MINUTE_MAX) : 16'd0;
					cdsc_pkg::UNIT_HOUR:
						v = $urandom_range(1) ? 16'(cdsc_pkg::HOUR_MAX) : 16'd0;
					cdsc_pkg::UNIT_DAY:    v = 16'($urandom_range(1) ? $urandom_range(32, 28)
						: $urandom_range(1));
					cdsc_pkg::UNIT_MONTH:  v = 16'($urandom_range(1) ? $urandom_range(13, 11)
						: $urandom_range(1));
					cdsc_pkg::UNIT_YEAR:   v = $urandom_range(1) ? 16'hFFFF : 16'd0;
					default:               v = 16'($urandom);
				endcase
			end else begin
				case (u)
					cdsc_pkg::UNIT_MINUTE: v = 16'($urandom_range(cdsc_pkg::MINUTE_MAX));
					cdsc_pkg::UNIT_HOUR:   v = 16'($urandom_range(cdsc_pkg::HOUR_MAX));
					cdsc_pkg::UNIT_DAY:    v = 16'($urandom_range(31, 1));
					cdsc_pkg::UNIT_MONTH:
						v = 16'($urandom_range(cdsc_pkg::MONTH_MAX, cdsc_pkg::MONTH_MIN));
					default:               v = 16'($urandom);
				endcase
			end
			send_item(op, u, v);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_total == 0 && dates_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
